>>> rtl/core/cmts_pkg.sv
// Shared types, token codes and keyword tables of the C-Minus token scanner.
package cmts_pkg;

  // Default widths of positions and number values.
  localparam int POSITION_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF    = 31;

  // Depths of the byte queue and of the token output buffer.
  localparam int QUEUE_DEPTH = 4;
  localparam int OBUF_DEPTH  = 4;

  localparam int KIND_W = 5;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_END      = 5'd0;
  localparam logic [KIND_W-1:0] K_ERROR    = 5'd1;
  localparam logic [KIND_W-1:0] K_IF       = 5'd2;
  localparam logic [KIND_W-1:0] K_PLUS     = 5'd8;
  localparam logic [KIND_W-1:0] K_MINUS    = 5'd9;
  localparam logic [KIND_W-1:0] K_TIMES    = 5'd10;
  localparam logic [KIND_W-1:0] K_DIVIDE   = 5'd11;
  localparam logic [KIND_W-1:0] K_LT       = 5'd12;
  localparam logic [KIND_W-1:0] K_LTE      = 5'd13;
  localparam logic [KIND_W-1:0] K_GT       = 5'd14;
  localparam logic [KIND_W-1:0] K_GTE      = 5'd15;
  localparam logic [KIND_W-1:0] K_EQ       = 5'd16;
  localparam logic [KIND_W-1:0] K_NEQ      = 5'd17;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd18;
  localparam logic [KIND_W-1:0] K_SEMI     = 5'd19;
  localparam logic [KIND_W-1:0] K_COMMA    = 5'd20;
  localparam logic [KIND_W-1:0] K_LPAREN   = 5'd21;
  localparam logic [KIND_W-1:0] K_RPAREN   = 5'd22;
  localparam logic [KIND_W-1:0] K_LBRACKET = 5'd23;
  localparam logic [KIND_W-1:0] K_RBRACKET = 5'd24;
  localparam logic [KIND_W-1:0] K_LBRACE   = 5'd25;
  localparam logic [KIND_W-1:0] K_RBRACE   = 5'd26;
  localparam logic [KIND_W-1:0] K_ID       = 5'd27;
  localparam logic [KIND_W-1:0] K_NUM      = 5'd28;

  // Keyword spellings, right-aligned in the six-byte window, in kind order.
  localparam int KW_COUNT = 6;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0000_6966, 48'h0000_656C_7365, 48'h0000_0069_6E74,
    48'h0000_766F_6964, 48'h7265_7475_726E, 48'h0077_6869_6C65
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd3, 3'd4, 3'd6, 3'd5};

  // One classified source byte as the front hands it to the back.
  typedef struct packed {
    logic [7:0]        char_code;
    logic              eoi;
    logic              alpha;
    logic              digit;
    logic              nl;
    logic              blank;
    logic              star;
    logic              slash;
    logic              eq;
    logic              lt;
    logic              gt;
    logic              bang;
    logic [KIND_W-1:0] single;
  } class_t;

  // Write strobes from the scanner into the output buffer.
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

  // Kind of a one-character punctuator or operator, K_END when there is none.
  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = K_END;
    case (c)
      8'h2B: k = K_PLUS;
      8'h2D: k = K_MINUS;
      8'h2A: k = K_TIMES;
      8'h3B: k = K_SEMI;
      8'h2C: k = K_COMMA;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h5B: k = K_LBRACKET;
      8'h5D: k = K_RBRACKET;
      8'h7B: k = K_LBRACE;
      8'h7D: k = K_RBRACE;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/cmts_in_if.sv
// Byte channel: one source byte or an end-of-input mark per beat.
interface cmts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

>>> rtl/core/cmts_out_if.sv
// Token channel: one scanned token per beat.
interface cmts_out_if #(
  parameter int POSITION_BITS = cmts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = cmts_pkg::VALUE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [cmts_pkg::KIND_W-1:0] token_kind;
  logic [POSITION_BITS-1:0]    token_line;
  logic [POSITION_BITS-1:0]    token_column;
  logic [POSITION_BITS-1:0]    token_length;
  logic [VALUE_BITS-1:0]       number_value;
  logic                        number_overflow;
  logic [7:0]                  error_char;
  logic                        last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_column,
                  output token_length, output number_value, output number_overflow,
                  output error_char, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_line, input token_column,
                input token_length, input number_value, input number_overflow,
                input error_char, input last_of_run, output ready);
endinterface

>>> rtl/core/cmts_front.sv
// Front end: accepts source bytes and classifies them for the scanner.
module cmts_front (
  cmts_in_if.sink          bytes,
  input  logic             full,
  output logic             push,
  output cmts_pkg::class_t cls
);

  logic [7:0] c;

  assign c           = bytes.char_code;
  assign bytes.ready = !full;
  assign push        = bytes.valid && !full;

  // Character classes; only ASCII letters and digits count.
  always_comb begin
    cls.char_code = c;
    cls.eoi       = bytes.end_of_input;
    cls.alpha     = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    cls.digit     = (c >= 8'h30 && c <= 8'h39);
    cls.nl        = (c == 8'h0A);
    cls.blank     = (c == 8'h20) || (c == 8'h09);
    cls.star      = (c == 8'h2A);
    cls.slash     = (c == 8'h2F);
    cls.eq        = (c == 8'h3D);
    cls.lt        = (c == 8'h3C);
    cls.gt        = (c == 8'h3E);
    cls.bang      = (c == 8'h21);
    cls.single    = cmts_pkg::single_kind(c);
  end

endmodule

>>> rtl/core/cmts_queue.sv
// Short queue of classified bytes between the front end and the scanner.
module cmts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cmts_pkg::class_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cmts_pkg::class_t head_data
);

  localparam int DEPTH = cmts_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmts_pkg::class_t entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[head];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/cmts_back.sv
// Scanner back end: runs the token state machine on classified bytes.
module cmts_back #(
  parameter int POSITION_BITS = cmts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = cmts_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  cmts_pkg::class_t        head,
  input  logic                    room,
  output logic                    pop,
  output cmts_pkg::push_t         push,
  output logic [cmts_pkg::KIND_W+3*POSITION_BITS+VALUE_BITS+9:0] tok_a,
  output logic [cmts_pkg::KIND_W+3*POSITION_BITS+VALUE_BITS+9:0] tok_b
);

  localparam int P     = POSITION_BITS;
  localparam int V     = VALUE_BITS;
  localparam int TOK_W = cmts_pkg::KIND_W + 3 * P + V + 10;

  // Scan modes.
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUMBER     = 4'd2;
  localparam logic [3:0] M_SLASH      = 4'd3;
  localparam logic [3:0] M_LT         = 4'd4;
  localparam logic [3:0] M_GT         = 4'd5;
  localparam logic [3:0] M_EQ         = 4'd6;
  localparam logic [3:0] M_BANG       = 4'd7;
  localparam logic [3:0] M_BLOCK      = 4'd8;
  localparam logic [3:0] M_BLOCK_STAR = 4'd9;
  localparam logic [3:0] M_LINE       = 4'd10;

  logic [3:0]  mode, mode_next;
  logic [P-1:0] line_count, line_count_next;
  logic [P-1:0] column_count, column_count_next;
  logic [P-1:0] start_column, start_column_next;
  logic [P-1:0] lexeme_length, lexeme_length_next;
  logic [V-1:0] accumulator, accumulator_next;
  logic         overflow, overflow_next;
  logic [47:0]  window, window_next;

  logic [V+3:0] product;
  logic [cmts_pkg::KIND_W-1:0] ident_kind;

  // Pending token of the current mode.
  logic                        pend_vld;
  logic [cmts_pkg::KIND_W-1:0] pend_kind;
  logic [P-1:0]                pend_len;
  logic [V-1:0]                pend_val;
  logic                        pend_ovf;
  logic [7:0]                  pend_ech;

  // First token (pending or two-character) and second token (new or end).
  logic                        f_vld, s_vld;
  logic [cmts_pkg::KIND_W-1:0] f_kind, s_kind;
  logic [P-1:0]                f_col, s_col, f_len, s_len;
  logic [V-1:0]                f_val;
  logic                        f_ovf;
  logic [7:0]                  f_ech, s_ech;
  logic                        consumed, do_flush;
  logic [TOK_W-1:0]            f_tok, s_tok;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == {P{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign pop = head_valid && room;

  // Next number value: ten times the accumulator plus the digit.
  assign product = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1)
                 + {{V{1'b0}}, head.char_code[3:0]};

  // Keyword match on length and the last six identifier bytes.
  always_comb begin
    ident_kind = cmts_pkg::K_ID;
    for (int i = 0; i < cmts_pkg::KW_COUNT; i++) begin
      if (lexeme_length == P'(cmts_pkg::KW_LEN[i]) && window == cmts_pkg::KW_TEXT[i]) begin
        ident_kind = cmts_pkg::K_IF + cmts_pkg::KIND_W'(i);
      end
    end
  end

  // Token that the current mode reports when it is cut short.
  always_comb begin
    pend_vld  = 1'b1;
    pend_kind = cmts_pkg::K_ID;
    pend_len  = P'(1);
    pend_val  = '0;
    pend_ovf  = 1'b0;
    pend_ech  = 8'h00;
    unique case (mode)
      M_IDENT: begin
        pend_kind = ident_kind;
        pend_len  = lexeme_length;
      end
      M_NUMBER: begin
        pend_kind = cmts_pkg::K_NUM;
        pend_len  = lexeme_length;
        pend_val  = accumulator;
        pend_ovf  = overflow;
      end
      M_SLASH: pend_kind = cmts_pkg::K_DIVIDE;
      M_LT:    pend_kind = cmts_pkg::K_LT;
      M_GT:    pend_kind = cmts_pkg::K_GT;
      M_EQ:    pend_kind = cmts_pkg::K_ASSIGN;
      M_BANG: begin
        pend_kind = cmts_pkg::K_ERROR;
        pend_ech  = 8'h21;
      end
      default: pend_vld = 1'b0;
    endcase
  end

  // Scanner step for the byte at the head of the queue.
  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    column_count_next  = column_count;
    start_column_next  = start_column;
    lexeme_length_next = lexeme_length;
    accumulator_next   = accumulator;
    overflow_next      = overflow;
    window_next        = window;
    f_vld    = 1'b0;
    f_kind   = cmts_pkg::K_END;
    f_col    = start_column;
    f_len    = '0;
    f_val    = '0;
    f_ovf    = 1'b0;
    f_ech    = 8'h00;
    s_vld    = 1'b0;
    s_kind   = cmts_pkg::K_END;
    s_col    = column_count;
    s_len    = P'(1);
    s_ech    = 8'h00;
    consumed = 1'b0;
    do_flush = 1'b0;

    if (head.eoi) begin
      // End mark: report what is pending, then the end token.
      do_flush  = 1'b1;
      s_vld     = 1'b1;
      s_len     = '0;
      mode_next = M_IDLE;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (head.alpha || head.digit) begin
            lexeme_length_next = sat_inc(lexeme_length);
            window_next        = {window[39:0], head.char_code};
            consumed           = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_NUMBER: begin
          if (head.digit) begin
            lexeme_length_next = sat_inc(lexeme_length);
            if (product[V+3:V] != 4'b0) begin
              accumulator_next = {V{1'b1}};
              overflow_next    = 1'b1;
            end else begin
              accumulator_next = product[V-1:0];
            end
            consumed = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_SLASH: begin
          if (head.star) begin
            mode_next = M_BLOCK;
            consumed  = 1'b1;
          end else if (head.slash) begin
            mode_next = M_LINE;
            consumed  = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_LT, M_GT, M_EQ, M_BANG: begin
          if (head.eq) begin
            f_vld = 1'b1;
            f_len = P'(2);
            unique case (mode)
              M_LT:    f_kind = cmts_pkg::K_LTE;
              M_GT:    f_kind = cmts_pkg::K_GTE;
              M_EQ:    f_kind = cmts_pkg::K_EQ;
              default: f_kind = cmts_pkg::K_NEQ;
            endcase
            mode_next = M_IDLE;
            consumed  = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        M_BLOCK: begin
          if (head.star) begin
            mode_next = M_BLOCK_STAR;
          end
          consumed = 1'b1;
        end
        M_BLOCK_STAR: begin
          if (head.slash) begin
            mode_next = M_IDLE;
          end else if (!head.star) begin
            mode_next = M_BLOCK;
          end
          consumed = 1'b1;
        end
        M_LINE: begin
          if (head.nl) begin
            mode_next = M_IDLE;
          end
          consumed = 1'b1;
        end
        default: mode_next = M_IDLE;
      endcase

      if (do_flush) begin
        mode_next = M_IDLE;
      end

      // A byte not taken by the mode starts over from idle.
      if (!consumed && !head.nl) begin
        if (head.alpha) begin
          mode_next          = M_IDENT;
          start_column_next  = column_count;
          lexeme_length_next = P'(1);
          window_next        = {40'b0, head.char_code};
        end else if (head.digit) begin
          mode_next          = M_NUMBER;
          start_column_next  = column_count;
          lexeme_length_next = P'(1);
          accumulator_next   = {{(V-4){1'b0}}, head.char_code[3:0]};
          overflow_next      = 1'b0;
        end else if (head.blank) begin
          mode_next = M_IDLE;
        end else if (head.slash || head.lt || head.gt || head.eq || head.bang) begin
          start_column_next = column_count;
          if (head.slash) begin
            mode_next = M_SLASH;
          end else if (head.lt) begin
            mode_next = M_LT;
          end else if (head.gt) begin
            mode_next = M_GT;
          end else if (head.eq) begin
            mode_next = M_EQ;
          end else begin
            mode_next = M_BANG;
          end
        end else begin
          s_vld = 1'b1;
          if (head.single != cmts_pkg::K_END) begin
            s_kind = head.single;
          end else begin
            s_kind = cmts_pkg::K_ERROR;
            s_ech  = head.char_code;
          end
        end
      end

      // Position tracking.
      if (head.nl) begin
        line_count_next   = sat_inc(line_count);
        column_count_next = P'(1);
      end else begin
        column_count_next = sat_inc(column_count);
      end
    end

    if (do_flush) begin
      f_vld  = pend_vld;
      f_kind = pend_kind;
      f_len  = pend_len;
      f_val  = pend_val;
      f_ovf  = pend_ovf;
      f_ech  = pend_ech;
    end
  end

  // Pack the tokens; a lone token always goes into the first slot.
  assign f_tok = {f_kind, line_count, f_col, f_len, f_val, f_ovf, f_ech, !s_vld};
  assign s_tok = {s_kind, line_count, s_col, s_len, {V{1'b0}}, 1'b0, s_ech, 1'b1};
  assign tok_a  = f_vld ? f_tok : s_tok;
  assign tok_b  = s_tok;
  assign push.a = pop && (f_vld || s_vld);
  assign push.b = pop && f_vld && s_vld;

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      line_count    <= P'(1);
      column_count  <= P'(1);
      start_column  <= P'(1);
      lexeme_length <= '0;
      accumulator   <= '0;
      overflow      <= 1'b0;
      window        <= '0;
    end else if (pop) begin
      mode          <= mode_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      start_column  <= start_column_next;
      lexeme_length <= lexeme_length_next;
      accumulator   <= accumulator_next;
      overflow      <= overflow_next;
      window        <= window_next;
    end
  end

`ifndef ASSERT_OFF
  // The second slot is written only together with the first.
  a_pair_order: assert property (@(posedge clk) disable iff (rst) push.b |-> push.a)
    else $error("second token slot written without the first");

  // Tokens are written only when the buffer has room for two.
  a_room: assert property (@(posedge clk) disable iff (rst) push.a |-> room)
    else $error("token written without buffer room");

  // Every end mark produces a token and leaves the scanner idle.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
      pop && head.eoi |-> push.a ##1 mode == M_IDLE)
    else $error("end of input did not close the scan");

  // A newline restarts the column.
  a_newline: assert property (@(posedge clk) disable iff (rst)
      pop && !head.eoi && head.nl |=> column_count == P'(1))
    else $error("column not reset after newline");
`endif

endmodule

>>> rtl/core/cmts_obuf.sv
// Token output buffer: takes up to two tokens per cycle, delivers one per beat.
module cmts_obuf #(
  parameter int POSITION_BITS = cmts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = cmts_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmts_pkg::push_t  push,
  input  logic [cmts_pkg::KIND_W+3*POSITION_BITS+VALUE_BITS+9:0] tok_a,
  input  logic [cmts_pkg::KIND_W+3*POSITION_BITS+VALUE_BITS+9:0] tok_b,
  output logic             room,
  cmts_out_if.source       tokens
);

  localparam int P     = POSITION_BITS;
  localparam int V     = VALUE_BITS;
  localparam int TOK_W = cmts_pkg::KIND_W + 3 * P + V + 10;
  localparam int DEPTH = cmts_pkg::OBUF_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field offsets inside a packed token.
  localparam int OFS_OVF  = 9;
  localparam int OFS_VAL  = 10;
  localparam int OFS_LEN  = OFS_VAL + V;
  localparam int OFS_COL  = OFS_LEN + P;
  localparam int OFS_LINE = OFS_COL + P;
  localparam int OFS_KIND = OFS_LINE + P;

  logic [TOK_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_plus;
  logic [CNT_W-1:0] count;
  logic [TOK_W-1:0] cur;
  logic             do_pop;

  assign tail_plus = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign do_pop    = tokens.valid && tokens.ready;
  assign cur       = entries[head];

  // Token fields of the oldest entry.
  assign tokens.valid           = (count != '0);
  assign tokens.token_kind      = cur[OFS_KIND +: cmts_pkg::KIND_W];
  assign tokens.token_line      = cur[OFS_LINE +: P];
  assign tokens.token_column    = cur[OFS_COL +: P];
  assign tokens.token_length    = cur[OFS_LEN +: P];
  assign tokens.number_value    = cur[OFS_VAL +: V];
  assign tokens.number_overflow = cur[OFS_OVF];
  assign tokens.error_char      = cur[8:1];
  assign tokens.last_of_run     = cur[0];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push.a) begin
      entries[tail] <= tok_a;
    end
    if (push.b) begin
      entries[tail_plus] <= tok_b;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push.b) begin
        tail <= (tail_plus == PTR_W'(DEPTH - 1)) ? '0 : tail_plus + 1'b1;
      end else if (push.a) begin
        tail <= tail_plus;
      end
      if (do_pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(push.a) + CNT_W'(push.b) - CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/c_minus_token_scanner.sv
// Top level of the C-Minus token scanner: front end, byte queue, scanner, output buffer.
//
//   channel  dir  beat                                   accepted when
//   bytes    in   char_code, end_of_input                valid && ready
//   tokens   out  kind, line, column, length, value,     valid && ready
//                 overflow, error_char, last_of_run
//
// One byte per cycle is taken while the four-entry byte queue has space.
// The scanner retires one byte per cycle when the token buffer has room for
// two tokens; a byte that yields two tokens writes both into the buffer at
// once, and the buffer drains one token per beat. A byte is registered in
// the byte queue and its tokens in the token buffer. Synchronous reset
// empties both queues and sets line and column to 1. A stalled token side
// fills the buffer, then the byte queue, and only then drops bytes.ready.
module c_minus_token_scanner #(
  parameter int POSITION_BITS = cmts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = cmts_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cmts_in_if.sink    bytes,
  cmts_out_if.source tokens
);

  localparam int TOK_W = cmts_pkg::KIND_W + 3 * POSITION_BITS + VALUE_BITS + 10;

  logic             q_full;
  logic             q_push;
  cmts_pkg::class_t q_in;
  logic             q_pop;
  logic             q_valid;
  cmts_pkg::class_t q_head;
  logic             room;
  cmts_pkg::push_t  push;
  logic [TOK_W-1:0] tok_a;
  logic [TOK_W-1:0] tok_b;

  cmts_front u_front (
    .bytes (bytes),
    .full  (q_full),
    .push  (q_push),
    .cls   (q_in)
  );

  cmts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  cmts_back #(
    .POSITION_BITS (POSITION_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .room       (room),
    .pop        (q_pop),
    .push       (push),
    .tok_a      (tok_a),
    .tok_b      (tok_b)
  );

  cmts_obuf #(
    .POSITION_BITS (POSITION_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_obuf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .tok_a  (tok_a),
    .tok_b  (tok_b),
    .room   (room),
    .tokens (tokens)
  );

endmodule

>>> tb/tb_c_minus_token_scanner.sv
// Self-checking testbench of the C-Minus token scanner with a byte driver and a token monitor.
`timescale 1ns / 1ps

module tb_c_minus_token_scanner;

  // One beat on the byte channel.
  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
  } source_byte_t;

  // One beat on the token channel.
  typedef struct packed {
    logic [cmts_pkg::KIND_W-1:0] kind;
    logic [15:0]       line;
    logic [15:0]       column;
    logic [15:0]       length;
    logic [30:0]       value;
    logic              ovf;
    logic [7:0]        err;
    logic              last;
  } token_t;

  // Lexer modes of the scanner.
  localparam logic [3:0] SM_IDLE       = 4'd0;
  localparam logic [3:0] SM_IDENT      = 4'd1;
  localparam logic [3:0] SM_NUMBER     = 4'd2;
  localparam logic [3:0] SM_SLASH      = 4'd3;
  localparam logic [3:0] SM_LT         = 4'd4;
  localparam logic [3:0] SM_GT         = 4'd5;
  localparam logic [3:0] SM_EQ         = 4'd6;
  localparam logic [3:0] SM_BANG       = 4'd7;
  localparam logic [3:0] SM_BLOCK      = 4'd8;
  localparam logic [3:0] SM_BLOCK_STAR = 4'd9;
  localparam logic [3:0] SM_LINE       = 4'd10;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
  localparam int RANDOM_BYTES = 1910;

  logic clk;
  logic rst;

  cmts_in_if  byte_ch ();
  cmts_out_if token_ch ();

  c_minus_token_scanner uut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .tokens(token_ch)
  );

  // Keyword spellings in kind order, right-aligned in a six-byte window.
  logic [47:0] keyword_spell [6];
  int          keyword_len [6];
  string       keyword_words [6];
  string       operator_words [12];
  string       punct_words [8];

  source_byte_t source_bytes [$];
  token_t       scanned_tokens [$];
  token_t       step_tokens [$];

  int total_items;
  int bytes_sent;
  int tokens_seen;
  int failures;
  logic steady;

  // Mirror of the scanner state.
  logic [3:0]  scan_mode;
  logic [15:0] line_count;
  logic [15:0] column_count;
  logic [15:0] start_column;
  logic [15:0] lexeme_length;
  logic [30:0] number_acc;
  logic        number_ovf;
  logic [47:0] ident_window;

  source_byte_t next_byte;
  token_t       got_token;
  token_t       want_token;

  // No idling at all while this stretch of the stream is on the wire.
  assign steady = (bytes_sent >= 600) && (bytes_sent < 900);

  always begin
    #5 clk = ~clk;
  end

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [cmts_pkg::KIND_W-1:0] punct_kind(logic [7:0] c);
    case (c)
      "+": return cmts_pkg::K_PLUS;
      "-": return cmts_pkg::K_MINUS;
      "*": return cmts_pkg::K_TIMES;
      ";": return cmts_pkg::K_SEMI;
      ",": return cmts_pkg::K_COMMA;
      "(": return cmts_pkg::K_LPAREN;
      ")": return cmts_pkg::K_RPAREN;
      "[": return cmts_pkg::K_LBRACKET;
      "]": return cmts_pkg::K_RBRACKET;
      "{": return cmts_pkg::K_LBRACE;
      "}": return cmts_pkg::K_RBRACE;
      default: return cmts_pkg::K_END;
    endcase
  endfunction

  function automatic void emit_token(logic [cmts_pkg::KIND_W-1:0] kind, logic [15:0] col,
                                     logic [15:0] len, logic [30:0] val, logic ovf,
                                     logic [7:0] err);
    token_t t;
    t = '{kind, line_count, col, len, val, ovf, err, 1'b0};
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  // Report whatever token the current mode holds; comments hold none.
  function automatic void close_pending();
    logic [cmts_pkg::KIND_W-1:0] k;
    k = cmts_pkg::K_ID;
    case (scan_mode)
      SM_IDENT: begin
        for (int i = 0; i < 6; i++) begin
          if (lexeme_length == 16'(keyword_len[i]) && ident_window == keyword_spell[i]) begin
            k = cmts_pkg::K_IF + cmts_pkg::KIND_W'(i);
          end
        end
        emit_token(k, start_column, lexeme_length, '0, 1'b0, 8'h00);
      end
      SM_NUMBER: emit_token(cmts_pkg::K_NUM, start_column, lexeme_length, number_acc,
                            number_ovf, 8'h00);
      SM_SLASH:  emit_token(cmts_pkg::K_DIVIDE, start_column, 16'd1, '0, 1'b0, 8'h00);
      SM_LT:     emit_token(cmts_pkg::K_LT, start_column, 16'd1, '0, 1'b0, 8'h00);
      SM_GT:     emit_token(cmts_pkg::K_GT, start_column, 16'd1, '0, 1'b0, 8'h00);
      SM_EQ:     emit_token(cmts_pkg::K_ASSIGN, start_column, 16'd1, '0, 1'b0, 8'h00);
      SM_BANG:   emit_token(cmts_pkg::K_ERROR, start_column, 16'd1, '0, 1'b0, "!");
      default: ;
    endcase
    scan_mode = SM_IDLE;
  endfunction

  // Advance the mirror by one accepted byte and queue the tokens it completes.
  function automatic void scan_byte(logic [7:0] c, logic eoi);
    logic        taken;
    logic [31:0] d;
    logic [cmts_pkg::KIND_W-1:0] k;
    step_tokens.delete();
    taken = 1'b0;
    if (eoi) begin
      close_pending();
      emit_token(cmts_pkg::K_END, column_count, 16'd0, '0, 1'b0, 8'h00);
    end else begin
      case (scan_mode)
        SM_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            lexeme_length = sat_up(lexeme_length);
            ident_window = {ident_window[39:0], c};
            taken = 1'b1;
          end else begin
            close_pending();
          end
        end
        SM_NUMBER: begin
          if (is_digit(c)) begin
            d = 32'(c - "0");
            lexeme_length = sat_up(lexeme_length);
            if ({1'b0, number_acc} > (32'(VALUE_MAX) - d) / 32'd10) begin
              number_acc = VALUE_MAX;
              number_ovf = 1'b1;
            end else begin
              number_acc = 31'(number_acc * 10 + d);
            end
            taken = 1'b1;
          end else begin
            close_pending();
          end
        end
        SM_SLASH: begin
          if (c == "*") begin
            scan_mode = SM_BLOCK;
            taken = 1'b1;
          end else if (c == "/") begin
            scan_mode = SM_LINE;
            taken = 1'b1;
          end else begin
            close_pending();
          end
        end
        SM_LT, SM_GT, SM_EQ, SM_BANG: begin
          if (c == "=") begin
            k = (scan_mode == SM_LT) ? cmts_pkg::K_LTE :
                (scan_mode == SM_GT) ? cmts_pkg::K_GTE :
                (scan_mode == SM_EQ) ? cmts_pkg::K_EQ : cmts_pkg::K_NEQ;
            emit_token(k, start_column, 16'd2, '0, 1'b0, 8'h00);
            scan_mode = SM_IDLE;
            taken = 1'b1;
          end else begin
            close_pending();
          end
        end
        SM_BLOCK: begin
          if (c == "*") scan_mode = SM_BLOCK_STAR;
          taken = 1'b1;
        end
        SM_BLOCK_STAR: begin
          if (c == "/") scan_mode = SM_IDLE;
          else if (c != "*") scan_mode = SM_BLOCK;
          taken = 1'b1;
        end
        SM_LINE: begin
          if (c == "\n") scan_mode = SM_IDLE;
          taken = 1'b1;
        end
        default: scan_mode = SM_IDLE;
      endcase

      // A byte not absorbed by the pending token starts a new one from idle.
      if (!taken && c != "\n") begin
        if (is_letter(c)) begin
          scan_mode = SM_IDENT;
          start_column = column_count;
          lexeme_length = 16'd1;
          ident_window = {40'd0, c};
        end else if (is_digit(c)) begin
          scan_mode = SM_NUMBER;
          start_column = column_count;
          lexeme_length = 16'd1;
          number_acc = 31'(c - "0");
          number_ovf = 1'b0;
        end else begin
          case (c)
            " ", "\t": ;
            "/": begin scan_mode = SM_SLASH; start_column = column_count; end
            "<": begin scan_mode = SM_LT;    start_column = column_count; end
            ">": begin scan_mode = SM_GT;    start_column = column_count; end
            "=": begin scan_mode = SM_EQ;    start_column = column_count; end
            "!": begin scan_mode = SM_BANG;  start_column = column_count; end
            default: begin
              k = punct_kind(c);
              if (k != cmts_pkg::K_END) emit_token(k, column_count, 16'd1, '0, 1'b0, 8'h00);
              else emit_token(cmts_pkg::K_ERROR, column_count, 16'd1, '0, 1'b0, c);
            end
          endcase
        end
      end

      if (c == "\n") begin
        line_count = sat_up(line_count);
        column_count = 16'd1;
      end else begin
        column_count = sat_up(column_count);
      end
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) scanned_tokens.insert(scanned_tokens.size(), step_tokens[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                tokens_seen, name, got, want));
    end
  endtask

  task automatic queue_beat(input logic [7:0] c, input logic eoi);
    source_byte_t b;
    b = '{c, eoi};
    source_bytes.insert(source_bytes.size(), b);
  endtask

  task automatic queue_char(input logic [7:0] c);
    queue_beat(c, 1'b0);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic queue_end_mark();
    queue_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // One random stretch of source text, mostly well formed.
  task automatic queue_fragment();
    string content;
    int    n;
    content = "ab*/ \n1=";
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        if ($urandom_range(0, 3) == 0) queue_char(8'($urandom_range("a", "z")));
        queue_text(keyword_words[$urandom_range(0, 5)]);
        if ($urandom_range(0, 3) == 0) queue_char(8'($urandom_range("0", "9")));
      end
      3, 4: begin
        n = $urandom_range(1, 9);
        queue_char($urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                        : 8'($urandom_range("a", "z")));
        for (int i = 1; i < n; i++) begin
          case ($urandom_range(0, 2))
            0: queue_char(8'($urandom_range("A", "Z")));
            1: queue_char(8'($urandom_range("a", "z")));
            default: queue_char(8'($urandom_range("0", "9")));
          endcase
        end
      end
      5, 6: begin
        case ($urandom_range(0, 7))
          0: queue_text("2147483647");
          1: queue_text("2147483648");
          2: queue_text("99999999999");
          default: begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) queue_char(8'($urandom_range("0", "9")));
          end
        endcase
      end
      7, 8, 9: queue_text(operator_words[$urandom_range(0, 11)]);
      10, 11: queue_text(punct_words[$urandom_range(0, 7)]);
      12, 13, 14: begin
        case ($urandom_range(0, 3))
          0: queue_char("\t");
          1: queue_char("\n");
          default: queue_char(" ");
        endcase
      end
      15: begin
        queue_text("/*");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) queue_char(content[$urandom_range(0, content.len() - 1)]);
        if ($urandom_range(0, 5) != 0) queue_text("*/");
      end
      16: begin
        queue_text("//");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) queue_char(8'($urandom_range(8'h20, 8'h7E)));
        queue_char("\n");
      end
      17: queue_char(8'($urandom_range(0, 255)));
      18: begin
        if ($urandom_range(0, 2) == 0) queue_end_mark();
        else queue_char(" ");
      end
      default: queue_char(content[$urandom_range(0, 3)]);
    endcase
    if ($urandom_range(0, 1) == 0) queue_char(" ");
  endtask

  // Byte driver: offers the next queued byte at random once the slot is free, and without pause in the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.char_code <= 8'h00;
      byte_ch.end_of_input <= 1'b0;
      bytes_sent = 0;
      scan_mode = SM_IDLE;
      line_count = 16'd1;
      column_count = 16'd1;
      start_column = 16'd1;
      lexeme_length = 16'd0;
      number_acc = '0;
      number_ovf = 1'b0;
      ident_window = '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        scan_byte(byte_ch.char_code, byte_ch.end_of_input);
        bytes_sent++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (source_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= 18)) begin
          next_byte = source_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.char_code <= next_byte.code;
          byte_ch.end_of_input <= next_byte.eoi;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Token monitor: every accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      token_ch.ready <= 1'b0;
      tokens_seen = 0;
      failures = 0;
    end else begin
      if (token_ch.valid && token_ch.ready) begin
        got_token = '{token_ch.token_kind, token_ch.token_line, token_ch.token_column,
                      token_ch.token_length, token_ch.number_value,
                      token_ch.number_overflow, token_ch.error_char, token_ch.last_of_run};
        if (scanned_tokens.size() == 0) begin
          report_mismatch($sformatf("token %0d of kind %0d arrived with none outstanding",
                                    tokens_seen, got_token.kind));
        end else begin
          want_token = scanned_tokens.pop_front();
          check_field("kind", got_token.kind, want_token.kind);
          check_field("line", got_token.line, want_token.line);
          check_field("column", got_token.column, want_token.column);
          check_field("length", got_token.length, want_token.length);
          check_field("value", got_token.value, want_token.value);
          check_field("overflow", got_token.ovf, want_token.ovf);
          check_field("error_char", got_token.err, want_token.err);
          check_field("last_of_run", got_token.last, want_token.last);
        end
        tokens_seen++;
      end
      token_ch.ready <= steady || ($urandom_range(0, 99) >= 18);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int base;
    clk = 1'b0;
    rst = 1'b1;

    keyword_words = '{"if", "else", "int", "void", "return", "while"};
    keyword_len = '{2, 4, 3, 4, 6, 5};
    foreach (keyword_words[i]) begin
      keyword_spell[i] = '0;
      for (int j = 0; j < keyword_words[i].len(); j++) begin
        keyword_spell[i] = {keyword_spell[i][39:0], keyword_words[i][j]};
      end
    end
    operator_words = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=", "=", "!"};
    punct_words = '{";", ",", "(", ")", "[", "]", "{", "}"};

    // Directed: compares, lone bang, comments, unknown bytes, tab, newline, end in a comment.
    queue_text("if<=>=!=!x/*a*/9");
    queue_char(8'h0D);
    queue_char(8'hFF);
    queue_text("\t==\n");
    queue_char(8'h00);
    queue_text("/*z");
    queue_end_mark();

    // Random source text, scanning on after each end mark.
    base = source_bytes.size();
    while (source_bytes.size() - base < RANDOM_BYTES) queue_fragment();
    queue_text("*/ ");
    queue_end_mark();
    queue_text("int a;");
    queue_end_mark();
    total_items = source_bytes.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent < total_items) @(posedge clk);
    while (scanned_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("tb_c_minus_token_scanner passed");
    end else begin
      $display("tb_c_minus_token_scanner failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("tb_c_minus_token_scanner failed");
    $finish;
  end

endmodule
